FILE: rtl/dmpid_pkg.sv
`timescale 1ns / 1ps

package dmpid_pkg;

    localparam int unsigned GAIN_FRAC_BITS_DEF = 8;

    localparam int unsigned GAIN_W     = 16;
    localparam int unsigned MEAS_W     = 16;
    localparam int unsigned ERR_W      = 17;
    localparam int unsigned DRIVE_W    = 17;
    localparam int unsigned LIMIT_W    = 17;
    localparam int unsigned OP_W       = 19;
    localparam int unsigned MUL_W      = GAIN_W + OP_W;
    localparam int unsigned INTEG_W    = 41;
    localparam int unsigned INTEG_EXP  = 39;
    localparam int unsigned SUM_W      = 44;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 17;

    localparam logic signed [LIMIT_W-1:0] OUT_MIN_RST = 17'sd0;
    localparam logic signed [LIMIT_W-1:0] OUT_MAX_RST = 17'sd50000;

    localparam logic MODE_INC = 1'b0;
    localparam logic MODE_POS = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = 3'd5;

    typedef struct packed {
        logic signed [MEAS_W-1:0] target;
        logic signed [MEAS_W-1:0] measured;
        logic                     clear;
    } t_in;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      hit_upper;
        logic                      hit_lower;
    } t_out;

    typedef struct packed {
        logic                      mode;
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic signed [LIMIT_W-1:0] out_min;
        logic signed [LIMIT_W-1:0] out_max;
    } t_cfg;

endpackage

FILE: rtl/dmpid_calc.sv
`timescale 1ns / 1ps

module dmpid_calc #(
    parameter int unsigned GAIN_FRAC_BITS = dmpid_pkg::GAIN_FRAC_BITS_DEF
) (
    input  dmpid_pkg::t_in                                            i_item,
    input  dmpid_pkg::t_cfg                                           i_cfg,
    input  logic signed [dmpid_pkg::ERR_W-1:0]                        i_err_last,
    input  logic signed [dmpid_pkg::ERR_W-1:0]                        i_err_prev,
    input  logic signed [dmpid_pkg::INTEG_W-1:0]                      i_integ,
    input  logic signed [dmpid_pkg::DRIVE_W+GAIN_FRAC_BITS-1:0]       i_held,
    output logic signed [dmpid_pkg::ERR_W-1:0]                        o_err_last,
    output logic signed [dmpid_pkg::ERR_W-1:0]                        o_err_prev,
    output logic signed [dmpid_pkg::INTEG_W-1:0]                      o_integ,
    output logic signed [dmpid_pkg::DRIVE_W+GAIN_FRAC_BITS-1:0]       o_held,
    output dmpid_pkg::t_out                                           o_result
);
    import dmpid_pkg::*;

    localparam int unsigned HELD_W = DRIVE_W + GAIN_FRAC_BITS;
    localparam logic signed [INTEG_W-1:0] INTEG_HI = INTEG_W'(1) <<< INTEG_EXP;
    localparam logic signed [INTEG_W-1:0] INTEG_LO = -INTEG_HI;

    logic signed [ERR_W-1:0]   e0;
    logic signed [OP_W-1:0]    d1;
    logic signed [OP_W-1:0]    d2;
    logic signed [OP_W-1:0]    op_p;
    logic signed [OP_W-1:0]    op_d;
    logic signed [MUL_W-1:0]   m_p;
    logic signed [MUL_W-1:0]   m_i;
    logic signed [MUL_W-1:0]   m_d;
    logic signed [INTEG_W-1:0] integ_acc;
    logic signed [INTEG_W-1:0] integ_n;
    logic signed [SUM_W-1:0]   base;
    logic signed [SUM_W-1:0]   v;
    logic signed [SUM_W-1:0]   hi;
    logic signed [SUM_W-1:0]   lo;
    logic signed [SUM_W-1:0]   v_up;
    logic signed [SUM_W-1:0]   v_clamp;
    logic                      up;
    logic                      dn;

    always_comb begin
        e0 = ERR_W'(i_item.target) - ERR_W'(i_item.measured);
        d1 = OP_W'(e0) - OP_W'(i_err_last);
        d2 = d1 - OP_W'(i_err_last) + OP_W'(i_err_prev);

        // positional uses e0 / first difference, incremental one order higher
        op_p = (i_cfg.mode == MODE_POS) ? OP_W'(e0) : d1;
        op_d = (i_cfg.mode == MODE_POS) ? d1 : d2;

        m_p = MUL_W'(i_cfg.gain_p) * MUL_W'(op_p);
        m_i = MUL_W'(i_cfg.gain_i) * MUL_W'(e0);
        m_d = MUL_W'(i_cfg.gain_d) * MUL_W'(op_d);

        integ_acc = i_integ + INTEG_W'(m_i);
        if (i_cfg.mode == MODE_POS) begin
            priority if (integ_acc > INTEG_HI) begin
                integ_n = INTEG_HI;
            end else if (integ_acc < INTEG_LO) begin
                integ_n = INTEG_LO;
            end else begin
                integ_n = integ_acc;
            end
        end else begin
            integ_n = INTEG_W'(m_i);
        end

        base = (i_cfg.mode == MODE_POS) ? '0 : SUM_W'(i_held);
        v = base + SUM_W'(m_p) + SUM_W'(integ_n) + SUM_W'(m_d);

        hi = SUM_W'(i_cfg.out_max) <<< GAIN_FRAC_BITS;
        lo = SUM_W'(i_cfg.out_min) <<< GAIN_FRAC_BITS;

        // upper bound first, lower bound wins on an inverted range
        up      = (v >= hi);
        v_up    = up ? hi : v;
        dn      = (v_up <= lo);
        v_clamp = dn ? lo : v_up;

        if (i_item.clear) begin
            o_err_last = '0;
            o_err_prev = '0;
            o_integ    = '0;
            o_held     = '0;
            o_result   = '0;
        end else begin
            o_err_last          = e0;
            o_err_prev          = i_err_last;
            o_integ             = integ_n;
            o_held              = v_clamp[HELD_W-1:0];
            o_result.drive      = v_clamp[GAIN_FRAC_BITS +: DRIVE_W];
            o_result.hit_upper  = up & ~dn;
            o_result.hit_lower  = dn;
        end
    end

endmodule

FILE: rtl/dual_mode_pid_controller.sv
`timescale 1ns / 1ps

// Dual-mode PID controller (incremental or positional) in fixed point. Each item
// carries target and measured; the error history, integral and held output are
// updated and one result item (drive plus clamp flags) comes back per item. An
// item is captured in the input register and is then computed combinationally into
// the output register, so a new item is taken every cycle while the output side
// keeps up; that rate is set by the loop from the held output and error history
// back into the datapath. Gains are signed Q8.8 by default, drive is the floor
// of the clamped output. Write configuration only while no item is in flight.

module dual_mode_pid_controller #(
    parameter int unsigned GAIN_FRAC_BITS = dmpid_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  dmpid_pkg::t_in                        i_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output dmpid_pkg::t_out                       o_out,
    input  logic                                  i_cfg_we,
    input  logic [dmpid_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [dmpid_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import dmpid_pkg::*;

    localparam int unsigned HELD_W = DRIVE_W + GAIN_FRAC_BITS;

    t_cfg                      r_cfg;
    t_in                       r_in_item;
    logic                      r_in_valid;
    t_out                      r_out_item;
    logic                      r_out_valid;
    logic signed [ERR_W-1:0]   r_err_last;
    logic signed [ERR_W-1:0]   r_err_prev;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [HELD_W-1:0]  r_held;

    logic signed [ERR_W-1:0]   n_err_last;
    logic signed [ERR_W-1:0]   n_err_prev;
    logic signed [INTEG_W-1:0] n_integ;
    logic signed [HELD_W-1:0]  n_held;
    t_out                      n_out_item;
    logic                      advance;

    assign advance     = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready  = ~r_in_valid | advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode    <= MODE_INC;
            r_cfg.gain_p  <= '0;
            r_cfg.gain_i  <= '0;
            r_cfg.gain_d  <= '0;
            r_cfg.out_min <= OUT_MIN_RST;
            r_cfg.out_max <= OUT_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE:    r_cfg.mode    <= i_cfg_data[0];
                REG_GAIN_P:  r_cfg.gain_p  <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_I:  r_cfg.gain_i  <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_D:  r_cfg.gain_d  <= i_cfg_data[GAIN_W-1:0];
                REG_OUT_MIN: r_cfg.out_min <= i_cfg_data[LIMIT_W-1:0];
                REG_OUT_MAX: r_cfg.out_max <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    dmpid_calc #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_calc (
        .i_item     (r_in_item),
        .i_cfg      (r_cfg),
        .i_err_last (r_err_last),
        .i_err_prev (r_err_prev),
        .i_integ    (r_integ),
        .i_held     (r_held),
        .o_err_last (n_err_last),
        .o_err_prev (n_err_prev),
        .o_integ    (n_integ),
        .o_held     (n_held),
        .o_result   (n_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_err_last  <= '0;
            r_err_prev  <= '0;
            r_integ     <= '0;
            r_held      <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_err_last  <= n_err_last;
                r_err_prev  <= n_err_prev;
                r_integ     <= n_integ;
                r_held      <= n_held;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload only
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in;
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dmpid_pkg::*;

    localparam int     FRAC        = GAIN_FRAC_BITS_DEF;
    localparam int     STALL_LIMIT = 2000;
    localparam int     HOLD_CYCLES = 300;
    localparam int     ITEM_GOAL   = 1100;
    localparam longint INTEG_SAT   = longint'(1) <<< INTEG_EXP;

    // tracks the controller state and the drive results still owed by the block
    class pid_tracker;
        t_cfg   regs;
        longint err_last;
        longint err_prev;
        longint integ;
        longint held;
        t_out   drive_queue[$];
        int     mismatches;

        function new();
            regs         = '0;
            regs.mode    = MODE_INC;
            regs.out_min = OUT_MIN_RST;
            regs.out_max = OUT_MAX_RST;
            err_last     = 0;
            err_prev     = 0;
            integ        = 0;
            held         = 0;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MODE:    regs.mode    = data[0];
                REG_GAIN_P:  regs.gain_p  = data[GAIN_W-1:0];
                REG_GAIN_I:  regs.gain_i  = data[GAIN_W-1:0];
                REG_GAIN_D:  regs.gain_d  = data[GAIN_W-1:0];
                REG_OUT_MIN: regs.out_min = data[LIMIT_W-1:0];
                REG_OUT_MAX: regs.out_max = data[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_item(t_in it);
            longint e0;
            longint v;
            longint hi;
            longint lo;
            longint one;
            t_out   res;
            res = '0;
            one = longint'(1) <<< FRAC;
            if (it.clear) begin
                err_last = 0;
                err_prev = 0;
                integ    = 0;
                held     = 0;
            end else begin
                e0 = longint'(it.target) - longint'(it.measured);
                if (regs.mode == MODE_INC) begin
                    // integral term is replaced, not accumulated, in this mode
                    integ = longint'(regs.gain_i) * e0;
                    v = held + longint'(regs.gain_p) * (e0 - err_last) + integ
                        + longint'(regs.gain_d) * (e0 - 2 * err_last + err_prev);
                end else begin
                    integ = integ + longint'(regs.gain_i) * e0;
                    if (integ > INTEG_SAT) integ = INTEG_SAT;
                    if (integ < -INTEG_SAT) integ = -INTEG_SAT;
                    v = longint'(regs.gain_p) * e0 + integ
                        + longint'(regs.gain_d) * (e0 - err_last);
                end
                hi = longint'(regs.out_max) * one;
                lo = longint'(regs.out_min) * one;
                // lower clamp wins when the range is inverted
                if (v >= hi) begin
                    v = hi;
                    res.hit_upper = 1'b1;
                end
                if (v <= lo) begin
                    v = lo;
                    res.hit_lower = 1'b1;
                    res.hit_upper = 1'b0;
                end
                held     = v;
                err_prev = err_last;
                err_last = e0;
                v = v >>> FRAC;
                res.drive = v[DRIVE_W-1:0];
            end
            drive_queue.push_back(res);
        endfunction

        function void take_result(t_out got);
            t_out want;
            if (drive_queue.size() == 0) begin
                $error("result item with nothing pending: drive %0d", got.drive);
                mismatches++;
                return;
            end
            want = drive_queue.pop_front();
            if (got.drive !== want.drive) begin
                $error("drive: expected %0d, got %0d", want.drive, got.drive);
                mismatches++;
            end
            if (got.hit_upper !== want.hit_upper) begin
                $error("hit_upper: expected %0b, got %0b", want.hit_upper, got.hit_upper);
                mismatches++;
            end
            if (got.hit_lower !== want.hit_lower) begin
                $error("hit_lower: expected %0b, got %0b", want.hit_lower, got.hit_lower);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in                   in_item;
    logic                  out_valid;
    logic                  out_ready;
    t_out                  out_item;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    pid_tracker sb;
    int         sent     = 0;
    int         quiet    = 0;
    bit         idle_on  = 1'b1;
    bit         hold_req = 1'b0;

    dual_mode_pid_controller dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic t_cfg make_cfg(logic mode, int gp, int gi, int gd, int mn, int mx);
        t_cfg c;
        c.mode    = mode;
        c.gain_p  = gp[GAIN_W-1:0];
        c.gain_i  = gi[GAIN_W-1:0];
        c.gain_d  = gd[GAIN_W-1:0];
        c.out_min = mn[LIMIT_W-1:0];
        c.out_max = mx[LIMIT_W-1:0];
        return c;
    endfunction

    function automatic int small_gain();
        return int'($urandom_range(0, 2048)) - 1024;
    endfunction

    function automatic int pick_gain();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0) return -32768;
        if (r == 1) return 32767;
        if (r == 2) return 0;
        if (r == 3) return int'($urandom_range(0, 65535)) - 32768;
        return small_gain();
    endfunction

    function automatic t_cfg random_settings();
        int r;
        int a;
        int b;
        r = $urandom_range(0, 4);
        a = int'($urandom_range(0, 4000)) - 2000;
        b = int'($urandom_range(0, 4000)) - 2000;
        if (r == 0) begin
            a = -65536;
            b = 65535;
        end else if (r == 1) begin
            if (a > b) begin
                r = a;
                a = b;
                b = r;
            end
        end else if (r == 2) begin
            // inverted range
            if (a < b) begin
                r = a;
                a = b;
                b = r;
            end
        end else if (r == 3) begin
            a = int'($urandom_range(0, 131071)) - 65536;
            b = int'($urandom_range(0, 131071)) - 65536;
        end else begin
            b = a;
        end
        return make_cfg(1'($urandom_range(0, 1)), pick_gain(), pick_gain(), pick_gain(),
                        a, b);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic load_settings(t_cfg c);
        write_reg(REG_MODE, CFG_DATA_W'(c.mode));
        write_reg(REG_GAIN_P, CFG_DATA_W'(c.gain_p));
        write_reg(REG_GAIN_I, CFG_DATA_W'(c.gain_i));
        write_reg(REG_GAIN_D, CFG_DATA_W'(c.gain_d));
        write_reg(REG_OUT_MIN, c.out_min);
        write_reg(REG_OUT_MAX, c.out_max);
        cfg_we <= 1'b0;
    endtask

    task automatic send(int target, int measured, bit clear);
        t_in item;
        item.target   = target[MEAS_W-1:0];
        item.measured = measured[MEAS_W-1:0];
        item.clear    = clear;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (!in_ready);
        sb.take_item(item);
        sent++;
    endtask

    task automatic send_random();
        int r;
        int t;
        r = $urandom_range(0, 19);
        t = int'($urandom_range(0, 400)) - 200;
        if (r == 0) begin
            send(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)), 1'b1);
        end else if (r <= 4) begin
            send(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)), 1'b0);
        end else begin
            // small error around the setpoint
            send(t, t + int'($urandom_range(0, 40)) - 20, 1'b0);
        end
    endtask

    // wait until every result is back and the pipe is empty
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.drive_queue.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_directed();
        load_settings(make_cfg(MODE_INC, 256, 32, -64, -65536, 65535));
        send(32767, -32768, 1'b0);
        send(-32768, 32767, 1'b0);
        send(0, 0, 1'b0);
        send(-32768, -32768, 1'b0);
        send(100, 37, 1'b0);
        send(5, 5, 1'b1);
        send(-7, 3, 1'b0);
        settle();
        // values landing exactly on each bound
        load_settings(make_cfg(MODE_POS, 256, 0, 0, -50, 100));
        send(100, 0, 1'b0);
        send(0, 50, 1'b0);
        send(99, 0, 1'b0);
        send(-49, 0, 1'b0);
        send(-1, 0, 1'b0);
        settle();
        // inverted range, clear with zero outside the range
        load_settings(make_cfg(MODE_POS, -32768, 32767, 32767, 10, -10));
        send(1, 0, 1'b0);
        send(0, 0, 1'b1);
        send(-300, 200, 1'b0);
        settle();
        // integral left by incremental mode carries into positional mode
        load_settings(make_cfg(MODE_INC, 0, 300, 0, -65536, 65535));
        send(3, 0, 1'b0);
        send(-5, 0, 1'b0);
        settle();
        load_settings(make_cfg(MODE_POS, 128, 300, 0, -65536, 65535));
        send(1, 0, 1'b0);
        send(-3, 0, 1'b0);
        send(32767, -32768, 1'b0);
        settle();
    endtask

    task automatic run_random();
        int phase;
        int count;
        phase = 0;
        while (sent < ITEM_GOAL) begin
            idle_on = (sent < ITEM_GOAL - 150) && ($urandom_range(0, 3) != 0);
            if (phase == 1 || phase == 4) begin
                // long run of large same-sign error drives the integral into saturation
                load_settings(make_cfg(MODE_POS, small_gain(), (phase == 1) ? 32767 : -32768,
                                       small_gain(), -65536, 65535));
                repeat (300) begin
                    send(int'($urandom_range(32000, 32767)),
                         -int'($urandom_range(32000, 32768)), 1'b0);
                end
                repeat (20) send_random();
            end else begin
                load_settings(random_settings());
                if (phase == 0) hold_req = 1'b1;
                count = $urandom_range(60, 110);
                repeat (count) send_random();
            end
            settle();
            phase++;
        end
    endtask

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        out_ready <= 1'b1;
        cfg_we    <= 1'b0;
        cfg_idx   <= '0;
        cfg_data  <= '0;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.drive_queue.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // output side: random stalls plus one long hold-off that backs up the block
    initial begin
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.take_result(out_item);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet <= 0;
            end else if (quiet >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

endmodule

FILE: filelist.f
rtl/dmpid_pkg.sv
rtl/dmpid_calc.sv
rtl/dual_mode_pid_controller.sv
sim/testbench.sv
